// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of the shortest-path block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion on clk, disabled while rst_n is low.
`define BF_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that an expression is never true.
`define BF_ASSERT_NEVER(label, expr, msg) `BF_ASSERT_CLK(label, !(expr), msg)

`endif

// ===== hdl/bf_pkg.sv =====
// Types and constants shared by the shortest-path block.
`default_nettype none

package bf_pkg;

    localparam int VERTEX_W    = 6;
    localparam int VCOUNT_W    = 7;
    localparam int WEIGHT_IN_W = 16;
    localparam int DIST_W      = 32;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 7;

    localparam logic [CFG_INDEX_W-1:0] CFG_START_VERTEX = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VERTEX_COUNT = 1'b1;

    localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
    localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

    // One edge in the relaxation stage, weight already sign extended.
    typedef struct packed {
        logic                     valid;
        logic [VERTEX_W-1:0]      src;
        logic [VERTEX_W-1:0]      dst;
        logic signed [DIST_W-1:0] weight;
    } relax_edge_t;

    // One write into the distance store.
    typedef struct packed {
        logic                     we;
        logic [VERTEX_W-1:0]      addr;
        logic signed [DIST_W-1:0] data;
    } dist_wr_t;

endpackage

`default_nettype wire

// ===== hdl/bf_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module bf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // A read of the address being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/bf_relax.sv =====
// Relaxation unit: forwarding, saturating add and the update decision for one edge.
`default_nettype none

module bf_relax
    import bf_pkg::*;
(
    input  wire relax_edge_t                 edge_in,
    input  wire logic signed [DIST_W-1:0]    rd_src,
    input  wire logic signed [DIST_W-1:0]    rd_dst,
    input  wire dist_wr_t                    fwd,
    input  wire logic                        reached_src,
    input  wire logic                        reached_dst,
    input  wire logic [VCOUNT_W-1:0]         nv,
    output dist_wr_t                         wr
);

    logic signed [DIST_W-1:0] dist_s;
    logic signed [DIST_W-1:0] dist_d;
    logic signed [DIST_W:0]   sum;
    logic signed [DIST_W-1:0] cand;
    logic                     in_range;
    logic                     take;

    always_comb
    begin
        // The previous cycle's write is not yet visible at the RAM output.
        dist_s = (fwd.we && (fwd.addr == edge_in.src)) ? fwd.data : rd_src;
        dist_d = (fwd.we && (fwd.addr == edge_in.dst)) ? fwd.data : rd_dst;

        sum = {dist_s[DIST_W-1], dist_s} + {edge_in.weight[DIST_W-1], edge_in.weight};
        if (sum[DIST_W] != sum[DIST_W-1])
        begin
            cand = sum[DIST_W] ? DIST_MIN : DIST_MAX;
        end
        else
        begin
            cand = sum[DIST_W-1:0];
        end

        in_range = ({1'b0, edge_in.src} < nv) && ({1'b0, edge_in.dst} < nv);
        take = edge_in.valid && in_range && reached_src
               && (!reached_dst || (cand < dist_d));

        wr.we   = take;
        wr.addr = edge_in.dst;
        wr.data = cand;
    end

endmodule

`default_nettype wire

// ===== hdl/bellman_ford_edge_list.sv =====
// Top level of the Bellman-Ford shortest-path block over a stored edge list.
// Edge words load at one per cycle while the block is idle; the word marked last starts a
// run that reads one edge per cycle over nv-1 passes (no pass when nv is one).
// Results then follow one per vertex, each read and then loaded, nv results per run.
// Reset clears the edge count, the overflow flag, the reached marks and the
// control state; the edge store is not cleared and the distance store is written at run start.
`default_nettype none

module bellman_ford_edge_list
    import bf_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 1024,
    parameter int WEIGHT_BITS  = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration write port
    input  wire logic                          cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]        cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         cfg_data,
    // edge input channel
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [VERTEX_W-1:0]           edge_source,
    input  wire logic [VERTEX_W-1:0]           edge_dest,
    input  wire logic signed [WEIGHT_IN_W-1:0] edge_weight,
    input  wire logic                          last_edge,
    // result channel
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [VERTEX_W-1:0]                vertex,
    output logic signed [DIST_W-1:0]           distance,
    output logic                               reachable,
    output logic                               edges_dropped,
    output logic                               last_result
);

    // Address widths of the two stores and the width of the edge counter,
    // which must also hold MAX_EDGES itself.
    localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EC_W = $clog2(MAX_EDGES + 1);
    localparam int VA_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int EW   = 2 * VERTEX_W + WEIGHT_BITS;
    // Weight bits that the input field can supply; a wider weight is zero extended.
    localparam int WK   = (WEIGHT_BITS < WEIGHT_IN_W) ? WEIGHT_BITS : WEIGHT_IN_W;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;  // loading edge words
    localparam logic [2:0] ST_INIT  = 3'd1;  // seed the start vertex
    localparam logic [2:0] ST_RUN   = 3'd2;  // issue one edge read per cycle
    localparam logic [2:0] ST_DRAIN = 3'd3;  // let the last edges write back
    localparam logic [2:0] ST_RD    = 3'd4;  // read the distance of one vertex
    localparam logic [2:0] ST_LD    = 3'd5;  // load it into the output register

    logic [2:0]                state_reg, state_next;
    logic [CFG_DATA_W-1:0]     unused_cfg;

    // Configuration registers.
    logic [VERTEX_W-1:0]       start_vertex_reg;
    logic [VCOUNT_W-1:0]       vertex_count_reg;

    // Load and run bookkeeping.
    logic [EC_W-1:0]           edge_count_reg, edge_count_next;
    logic                      overflow_reg, overflow_next;
    logic [VCOUNT_W-1:0]       nv_reg, nv_next, nv_sat;
    logic [EA_W-1:0]           edge_idx_reg, edge_idx_next;
    logic [VERTEX_W-1:0]       pass_reg, pass_next;
    logic [VERTEX_W-1:0]       vtx_reg, vtx_next;
    logic [MAX_VERTICES-1:0]   reached_reg, reached_next;

    // Relaxation pipeline: stage one has the edge word at the edge RAM output,
    // stage two has both distances at the distance RAM outputs.
    logic                      s1_valid_reg;
    logic                      s2_valid_reg;
    logic [VERTEX_W-1:0]       s2_src_reg;
    logic [VERTEX_W-1:0]       s2_dst_reg;
    logic [WEIGHT_BITS-1:0]    s2_weight_reg;
    dist_wr_t                  fwd_reg;

    // Output register.
    logic                      out_valid_reg, out_valid_next;
    logic [VERTEX_W-1:0]       vertex_reg, vertex_next;
    logic signed [DIST_W-1:0]  distance_reg, distance_next;
    logic                      reachable_reg, reachable_next;
    logic                      dropped_reg, dropped_next;
    logic                      last_reg, last_next;

    // Store ports.
    logic                      edge_we;
    logic [EW-1:0]             edge_wdata;
    logic [EW-1:0]             edge_rdata;
    logic [VERTEX_W-1:0]       rd_src_field;
    logic [VERTEX_W-1:0]       rd_dst_field;
    logic [VERTEX_W-1:0]       dist_raddr_a;
    logic signed [DIST_W-1:0]  dist_rdata_a;
    logic signed [DIST_W-1:0]  dist_rdata_b;
    logic                      init_we;
    dist_wr_t                  relax_wr;
    dist_wr_t                  dist_wr;
    relax_edge_t               s2_edge;

    logic                      end_of_pass;
    logic                      last_pass;
    logic                      last_vertex;

    assign in_ready = (state_reg == ST_IDLE);

    // Only the low bits of the data word carry the start vertex.
    assign unused_cfg = cfg_data;

    // The vertex count is taken as at least one and at most the store size.
    always_comb
    begin
        if (vertex_count_reg == '0)
        begin
            nv_sat = VCOUNT_W'(1);
        end
        else if (vertex_count_reg > VCOUNT_W'(MAX_VERTICES))
        begin
            nv_sat = VCOUNT_W'(MAX_VERTICES);
        end
        else
        begin
            nv_sat = vertex_count_reg;
        end
    end

    // Edge store: one word per edge, source and destination above the weight.
    assign edge_wdata   = {edge_source, edge_dest, WEIGHT_BITS'(edge_weight[WK-1:0])};
    assign rd_src_field = edge_rdata[EW-1 -: VERTEX_W];
    assign rd_dst_field = edge_rdata[WEIGHT_BITS +: VERTEX_W];

    bf_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_count_reg[EA_W-1:0]),
        .wdata (edge_wdata),
        .raddr (edge_idx_reg),
        .rdata (edge_rdata)
    );

    // The distance store is kept in two copies that are always written
    // together, so that source and destination can be read in the same cycle.
    // Port A also serves the result readout.
    assign dist_raddr_a = ((state_reg == ST_RD) || (state_reg == ST_LD)) ? vtx_reg
                                                                         : rd_src_field;

    always_comb
    begin
        if (init_we)
        begin
            dist_wr.we   = 1'b1;
            dist_wr.addr = start_vertex_reg;
            dist_wr.data = '0;
        end
        else
        begin
            dist_wr = relax_wr;
        end
    end

    bf_ram #(
        .WIDTH (DIST_W),
        .DEPTH (MAX_VERTICES)
    ) u_dist_a (
        .clk   (clk),
        .we    (dist_wr.we),
        .waddr (dist_wr.addr[VA_W-1:0]),
        .wdata (dist_wr.data),
        .raddr (dist_raddr_a[VA_W-1:0]),
        .rdata (dist_rdata_a)
    );

    bf_ram #(
        .WIDTH (DIST_W),
        .DEPTH (MAX_VERTICES)
    ) u_dist_b (
        .clk   (clk),
        .we    (dist_wr.we),
        .waddr (dist_wr.addr[VA_W-1:0]),
        .wdata (dist_wr.data),
        .raddr (rd_dst_field[VA_W-1:0]),
        .rdata (dist_rdata_b)
    );

    // Stage two feeds the relaxation unit. The reached marks are flip-flops,
    // so the previous edge's mark update is already visible here.
    always_comb
    begin
        s2_edge.valid  = s2_valid_reg;
        s2_edge.src    = s2_src_reg;
        s2_edge.dst    = s2_dst_reg;
        s2_edge.weight = DIST_W'(signed'(s2_weight_reg));
    end

    bf_relax u_relax (
        .edge_in     (s2_edge),
        .rd_src      (dist_rdata_a),
        .rd_dst      (dist_rdata_b),
        .fwd         (fwd_reg),
        .reached_src (reached_reg[s2_src_reg[VA_W-1:0]]),
        .reached_dst (reached_reg[s2_dst_reg[VA_W-1:0]]),
        .nv          (nv_reg),
        .wr          (relax_wr)
    );

    // Run sequencing: edge index wraps each pass, passes run 0 .. nv-2.
    assign end_of_pass = ({{(EC_W-EA_W){1'b0}}, edge_idx_reg} == (edge_count_reg - 1'b1));
    assign last_pass   = ({1'b0, pass_reg} == (nv_reg - VCOUNT_W'(2)));
    assign last_vertex = (({1'b0, vtx_reg} + 1'b1) == nv_reg);

    always_comb
    begin
        state_next      = state_reg;
        edge_count_next = edge_count_reg;
        overflow_next   = overflow_reg;
        nv_next         = nv_reg;
        edge_idx_next   = edge_idx_reg;
        pass_next       = pass_reg;
        vtx_next        = vtx_reg;
        reached_next    = reached_reg;
        out_valid_next  = out_valid_reg;
        vertex_next     = vertex_reg;
        distance_next   = distance_reg;
        reachable_next  = reachable_reg;
        dropped_next    = dropped_reg;
        last_next       = last_reg;
        edge_we         = 1'b0;
        init_we         = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (relax_wr.we)
        begin
            reached_next[relax_wr.addr[VA_W-1:0]] = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (edge_count_reg < EC_W'(MAX_EDGES))
                    begin
                        edge_we         = 1'b1;
                        edge_count_next = edge_count_reg + 1'b1;
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    if (last_edge)
                    begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                nv_next       = nv_sat;
                reached_next  = '0;
                edge_idx_next = '0;
                pass_next     = '0;
                vtx_next      = '0;
                // A start vertex outside the graph leaves every vertex unreached.
                if ({1'b0, start_vertex_reg} < nv_sat)
                begin
                    reached_next[start_vertex_reg[VA_W-1:0]] = 1'b1;
                    init_we = 1'b1;
                end
                // A single vertex needs no passes.
                state_next = (nv_sat == VCOUNT_W'(1)) ? ST_RD : ST_RUN;
            end
            ST_RUN:
            begin
                if (end_of_pass)
                begin
                    edge_idx_next = '0;
                    pass_next     = pass_reg + 1'b1;
                    if (last_pass)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
                else
                begin
                    edge_idx_next = edge_idx_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                if (!s1_valid_reg && !s2_valid_reg)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_LD;
            end
            ST_LD:
            begin
                // The read address stays on this vertex, so the data holds
                // while the output register is still occupied.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    vertex_next    = vtx_reg;
                    reachable_next = reached_reg[vtx_reg[VA_W-1:0]];
                    distance_next  = reached_reg[vtx_reg[VA_W-1:0]] ? dist_rdata_a : '0;
                    dropped_next   = overflow_reg;
                    last_next      = last_vertex;
                    if (last_vertex)
                    begin
                        edge_count_next = '0;
                        overflow_next   = 1'b0;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        vtx_next   = vtx_reg + 1'b1;
                        state_next = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            start_vertex_reg <= '0;
            vertex_count_reg <= VCOUNT_W'(64);
            edge_count_reg   <= '0;
            overflow_reg     <= 1'b0;
            nv_reg           <= VCOUNT_W'(1);
            edge_idx_reg     <= '0;
            pass_reg         <= '0;
            vtx_reg          <= '0;
            reached_reg      <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            fwd_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            edge_count_reg <= edge_count_next;
            overflow_reg   <= overflow_next;
            nv_reg         <= nv_next;
            edge_idx_reg   <= edge_idx_next;
            pass_reg       <= pass_next;
            vtx_reg        <= vtx_next;
            reached_reg    <= reached_next;
            s1_valid_reg   <= (state_reg == ST_RUN);
            s2_valid_reg   <= s1_valid_reg;
            fwd_reg        <= dist_wr;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_START_VERTEX: start_vertex_reg <= unused_cfg[VERTEX_W-1:0];
                    CFG_VERTEX_COUNT: vertex_count_reg <= unused_cfg;
                    default:          vertex_count_reg <= vertex_count_reg;
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        s2_src_reg    <= rd_src_field;
        s2_dst_reg    <= rd_dst_field;
        s2_weight_reg <= edge_rdata[WEIGHT_BITS-1:0];
        vertex_reg    <= vertex_next;
        distance_reg  <= distance_next;
        reachable_reg <= reachable_next;
        dropped_reg   <= dropped_next;
        last_reg      <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign vertex        = vertex_reg;
    assign distance      = distance_reg;
    assign reachable     = reachable_reg;
    assign edges_dropped = dropped_reg;
    assign last_result   = last_reg;

endmodule

`default_nettype wire

// ===== hdl/bf_checker.sv =====
// Port-level checker for the shortest-path block and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module bf_checker
    import bf_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     in_valid,
    input wire logic                     in_ready,
    input wire logic                     last_edge,
    input wire logic                     out_valid,
    input wire logic                     out_ready,
    input wire logic [VERTEX_W-1:0]      vertex,
    input wire logic signed [DIST_W-1:0] distance,
    input wire logic                     reachable,
    input wire logic                     last_result
);

    // A stalled result word keeps its payload.
    `BF_ASSERT_CLK(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(vertex) && $stable(distance) && $stable(reachable) && $stable(last_result)), "result word changed while stalled")

    // The last edge word of a load closes the input until the run is done.
    `BF_ASSERT_CLK(a_run_closes_input, (in_valid && in_ready && last_edge) |=> !in_ready, "input open right after the last edge word")

    // An unreached vertex reports a zero distance.
    `BF_ASSERT_NEVER(a_unreached_zero, out_valid && !reachable && (distance != '0), "unreached vertex with nonzero distance")

    // Results of one run come out in vertex order.
    `BF_ASSERT_CLK(a_vertex_order, (out_valid && out_ready && !last_result) |=> (!out_valid || (vertex == $past(vertex) + 6'd1)), "result words out of vertex order")

    // The word after the final result of a run opens the next run at vertex zero.
    `BF_ASSERT_CLK(a_next_run_start, (out_valid && out_ready && last_result) |=> (!out_valid || (vertex == '0)), "next run does not start at vertex zero")

endmodule

bind bellman_ford_edge_list bf_checker u_bf_checker (.*);

`default_nettype wire

// ===== test/bf_checker.sv =====
// Checker for the shortest-path block: tracks register writes and edge words, predicts results.
module bf_tb_checker
    import bf_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 1024,
    parameter int WEIGHT_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [VERTEX_W-1:0]           edge_source,
    input  logic [VERTEX_W-1:0]           edge_dest,
    input  logic signed [WEIGHT_IN_W-1:0] edge_weight,
    input  logic                          last_edge,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [VERTEX_W-1:0]           vertex,
    input  logic signed [DIST_W-1:0]      distance,
    input  logic                          reachable,
    input  logic                          edges_dropped,
    input  logic                          last_result,
    output int                            mismatches,
    output int                            outstanding
);

    typedef struct packed {
        logic [VERTEX_W-1:0]      src;
        logic [VERTEX_W-1:0]      dst;
        logic signed [DIST_W-1:0] weight;
    } graph_edge_t;

    typedef struct packed {
        logic [VERTEX_W-1:0]      vertex;
        logic signed [DIST_W-1:0] distance;
        logic                     reachable;
        logic                     dropped;
        logic                     last;
    } vertex_result_t;

    // Shadow copy of the block's registers and edge store.
    logic [VERTEX_W-1:0]      start_reg;
    logic [VCOUNT_W-1:0]      count_reg;
    graph_edge_t              edge_list [MAX_EDGES];
    int                       edge_total;
    logic                     store_overflowed;

    // Working storage of the path solver.
    logic signed [DIST_W-1:0] dist_est [MAX_VERTICES];
    logic                     reached [MAX_VERTICES];
    int                       nv;
    longint                   sum;
    longint                   wide_weight;
    logic signed [DIST_W-1:0] cand;
    logic [VERTEX_W-1:0]      s_idx;
    logic [VERTEX_W-1:0]      d_idx;
    vertex_result_t           want;
    vertex_result_t           expected_results [$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    task automatic report_mismatch(input string what);
        $display("checker: %s", what);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start_reg        = '0;
            count_reg        = 7'd64;
            edge_total       = 0;
            store_overflowed = 1'b0;
            expected_results.delete();
        end
        else begin
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result for vertex %0d with nothing expected",
                                              vertex));
                end
                else begin
                    want = expected_results.pop_front();
                    if (vertex !== want.vertex)
                        report_mismatch($sformatf("vertex %0d, expected %0d",
                                                  vertex, want.vertex));
                    if (distance !== want.distance)
                        report_mismatch($sformatf("vertex %0d: distance %0d, expected %0d",
                                                  want.vertex, distance, want.distance));
                    if (reachable !== want.reachable)
                        report_mismatch($sformatf("vertex %0d: reachable %b, expected %b",
                                                  want.vertex, reachable, want.reachable));
                    if (edges_dropped !== want.dropped)
                        report_mismatch($sformatf("vertex %0d: edges_dropped %b, expected %b",
                                                  want.vertex, edges_dropped, want.dropped));
                    if (last_result !== want.last)
                        report_mismatch($sformatf("vertex %0d: last_result %b, expected %b",
                                                  want.vertex, last_result, want.last));
                end
            end

            if (cfg_we) begin
                if (cfg_index == CFG_START_VERTEX)
                    start_reg = cfg_data[VERTEX_W-1:0];
                else if (cfg_index == CFG_VERTEX_COUNT)
                    count_reg = cfg_data[VCOUNT_W-1:0];
            end

            if (in_valid && in_ready) begin
                if (edge_total < MAX_EDGES) begin
                    wide_weight = edge_weight[WEIGHT_BITS-1:0];
                    if (edge_weight[WEIGHT_BITS-1])
                        wide_weight -= longint'(1) << WEIGHT_BITS;
                    edge_list[edge_total].src    = edge_source;
                    edge_list[edge_total].dst    = edge_dest;
                    edge_list[edge_total].weight = wide_weight[DIST_W-1:0];
                    edge_total++;
                end
                else begin
                    store_overflowed = 1'b1;
                end

                if (last_edge) begin
                    nv = (count_reg == 0) ? 1 :
                         (count_reg > MAX_VERTICES) ? MAX_VERTICES : int'(count_reg);
                    for (int v = 0; v < MAX_VERTICES; v++) begin
                        dist_est[v] = '0;
                        reached[v]  = 1'b0;
                    end
                    if (start_reg < nv)
                        reached[start_reg] = 1'b1;

                    // nv-1 passes over the edges in load order; edges touching a vertex
                    // outside the graph and edges leaving an unreached vertex are skipped.
                    for (int p = 1; p < nv; p++) begin
                        for (int e = 0; e < edge_total; e++) begin
                            s_idx = edge_list[e].src;
                            d_idx = edge_list[e].dst;
                            if (s_idx < nv && d_idx < nv && reached[s_idx]) begin
                                sum = longint'(dist_est[s_idx]) + longint'(edge_list[e].weight);
                                if (sum > longint'(DIST_MAX))
                                    cand = DIST_MAX;
                                else if (sum < longint'(DIST_MIN))
                                    cand = DIST_MIN;
                                else
                                    cand = sum[DIST_W-1:0];
                                if (!reached[d_idx] || cand < dist_est[d_idx]) begin
                                    dist_est[d_idx] = cand;
                                    reached[d_idx]  = 1'b1;
                                end
                            end
                        end
                    end

                    for (int v = 0; v < nv; v++) begin
                        want.vertex    = v[VERTEX_W-1:0];
                        want.distance  = reached[v] ? dist_est[v] : '0;
                        want.reachable = reached[v];
                        want.dropped   = store_overflowed;
                        want.last      = (v == nv - 1);
                        expected_results = {expected_results, want};
                    end
                    edge_total       = 0;
                    store_overflowed = 1'b0;
                end
            end
        end
        outstanding = expected_results.size();
    end

endmodule

// ===== test/tb.sv =====
// Testbench top for the shortest-path block: stimulus, idling on both channels and the verdict.
module tb;
    import bf_pkg::*;

    localparam int MAX_VERTICES  = 64;
    localparam int MAX_EDGES     = 1024;
    localparam int WEIGHT_BITS   = 16;
    // Rough size of the random part, in edge words.
    localparam int RANDOM_WORDS  = 130;
    // Cycles allowed after the last result before the block counts as idle.
    localparam int SETTLE_CYCLES = 16;
    // Hard stop for a hung run, in time units.
    localparam int RUN_LIMIT     = 5_000_000;

    // All block inputs start at known values at time zero.
    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          cfg_we      = 1'b0;
    logic [CFG_INDEX_W-1:0]        cfg_index   = '0;
    logic [CFG_DATA_W-1:0]         cfg_data    = '0;
    logic                          in_valid    = 1'b0;
    logic [VERTEX_W-1:0]           edge_source = '0;
    logic [VERTEX_W-1:0]           edge_dest   = '0;
    logic signed [WEIGHT_IN_W-1:0] edge_weight = '0;
    logic                          last_edge   = 1'b0;
    logic                          out_ready   = 1'b0;

    logic                          in_ready;
    logic                          out_valid;
    logic [VERTEX_W-1:0]           vertex;
    logic signed [DIST_W-1:0]      distance;
    logic                          reachable;
    logic                          edges_dropped;
    logic                          last_result;

    int mismatches;
    int outstanding;

    // Percent of cycles in which the edge sender holds back and the result
    // receiver refuses a word. Changed by the stimulus as the run goes on.
    int send_idle_pct = 20;
    int recv_idle_pct = 74;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    bellman_ford_edge_list #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .edge_source   (edge_source),
        .edge_dest     (edge_dest),
        .edge_weight   (edge_weight),
        .last_edge     (last_edge),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .vertex        (vertex),
        .distance      (distance),
        .reachable     (reachable),
        .edges_dropped (edges_dropped),
        .last_result   (last_result)
    );

    // The checker sits beside the block, watches both channels and the
    // register port, and reports its mismatch count and open expectations.
    bf_tb_checker #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_EDGES    (MAX_EDGES),
        .WEIGHT_BITS  (WEIGHT_BITS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .edge_source   (edge_source),
        .edge_dest     (edge_dest),
        .edge_weight   (edge_weight),
        .last_edge     (last_edge),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .vertex        (vertex),
        .distance      (distance),
        .reachable     (reachable),
        .edges_dropped (edges_dropped),
        .last_result   (last_result),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // The receiver decides afresh on every falling edge whether it takes a word.
    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Writes one register. The enable is held for a single cycle and then
    // dropped, so back-to-back writes never touch it twice in a step.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // Offers one edge word and returns at the falling edge after it is taken.
    // Valid is left high, so the next word can follow without a gap; a gap,
    // when one is drawn, lowers valid in a step of its own.
    task automatic send_edge(input int src, input int dst, input int weight, input bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        edge_source <= src[VERTEX_W-1:0];
        edge_dest   <= dst[VERTEX_W-1:0];
        edge_weight <= weight[WEIGHT_IN_W-1:0];
        last_edge   <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drops valid, waits for every expected result, then lets the block wind down.
    task automatic settle();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial begin : stimulus
        int sent;
        int count_value;
        int start_value;
        int nv;
        int loads;
        int n;
        int k;
        int src;
        int dst;
        int prev;
        int weight;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        repeat (3) @(negedge clk);

        // Directed part. The registers still hold their reset values here:
        // start at vertex 0 in a graph of 64 vertices. The load reaches vertex 63,
        // uses both weight extremes, a self loop, a worse second route to 63 and
        // an edge leaving a vertex that is never reached.
        send_edge(0, 1, 32767, 1'b0);
        send_edge(1, 2, -32768, 1'b0);
        send_edge(2, 63, 5, 1'b0);
        send_edge(63, 0, -1, 1'b0);
        send_edge(5, 6, 7, 1'b0);
        send_edge(0, 63, 100, 1'b0);
        send_edge(63, 63, 0, 1'b1);
        settle();

        // A count of zero acts as a single vertex. The start register is written
        // with its unused top bit set, leaving vertex 63, which lies outside.
        write_reg(CFG_START_VERTEX, 7'h7F);
        write_reg(CFG_VERTEX_COUNT, 0);
        send_edge(0, 0, 5, 1'b1);
        settle();

        // Single vertex that is also the start: no passes, distance zero.
        write_reg(CFG_START_VERTEX, 0);
        write_reg(CFG_VERTEX_COUNT, 1);
        send_edge(0, 0, -3, 1'b1);
        settle();

        // Four vertices from vertex 2: an unreached destination is taken at once,
        // a longer route does not replace a shorter one, and edges with an endpoint
        // beyond the graph are ignored.
        write_reg(CFG_START_VERTEX, 2);
        write_reg(CFG_VERTEX_COUNT, 4);
        send_edge(2, 3, -7, 1'b0);
        send_edge(3, 1, 4, 1'b0);
        send_edge(2, 1, 0, 1'b0);
        send_edge(1, 9, 1, 1'b0);
        send_edge(12, 0, 1, 1'b0);
        send_edge(3, 0, -32768, 1'b1);
        settle();

        // A count above the maximum saturates to 64; a negative cycle keeps
        // pulling both of its vertices down on every pass.
        write_reg(CFG_START_VERTEX, 10);
        write_reg(CFG_VERTEX_COUNT, 127);
        send_edge(10, 11, -5, 1'b0);
        send_edge(11, 10, -5, 1'b1);
        settle();

        // Start vertex outside a graph of three: nothing is reachable.
        write_reg(CFG_START_VERTEX, 5);
        write_reg(CFG_VERTEX_COUNT, 3);
        send_edge(0, 1, 1, 1'b1);
        settle();

        // Random part. Each round picks a configuration, then sends one to three
        // loads. About half of the edges grow a path out of the start vertex so that the
        // relaxation has real work; the rest go anywhere, some beyond the graph.
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            if (sent >= 2 * RANDOM_WORDS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else if (sent >= RANDOM_WORDS / 3) begin
                send_idle_pct = 74;
                recv_idle_pct = 20;
            end

            k = $urandom_range(9);
            if (k == 0)
                count_value = 0;
            else if (k == 1)
                count_value = 1;
            else if (k == 2)
                count_value = 64;
            else if (k == 3)
                count_value = $urandom_range(127, 65);
            else
                count_value = $urandom_range(12, 2);
            nv = (count_value == 0) ? 1 : (count_value > MAX_VERTICES) ? MAX_VERTICES :
                 count_value;

            if ($urandom_range(99) < 80)
                start_value = $urandom_range(nv - 1);
            else
                start_value = $urandom_range(127);

            write_reg(CFG_START_VERTEX, start_value);
            write_reg(CFG_VERTEX_COUNT, count_value);

            loads = $urandom_range(3, 1);
            for (int l = 0; l < loads; l++) begin
                n    = $urandom_range(10, 1);
                prev = start_value % 64;
                for (int i = 0; i < n; i++) begin
                    k = $urandom_range(99);
                    if (k < 10)
                        src = $urandom_range(63);
                    else if (k < 60)
                        src = prev;
                    else
                        src = $urandom_range(nv - 1);

                    if ($urandom_range(99) < 10)
                        dst = $urandom_range(63);
                    else
                        dst = $urandom_range(nv - 1);
                    if (dst < nv)
                        prev = dst;

                    k = $urandom_range(99);
                    if (k < 15)
                        weight = int'($urandom_range(65535));
                    else if (k < 18)
                        weight = 32767;
                    else if (k < 22)
                        weight = -32768;
                    else
                        weight = int'($urandom_range(250)) - 50;

                    send_edge(src, dst, weight, i == n - 1);
                end
                sent += n;
            end
            settle();
        end

        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // Watchdog in case the block stops accepting words or stops answering.
    initial begin
        #(RUN_LIMIT);
        $display("tb: FAIL");
        $finish;
    end

endmodule
